@@ rtl/ppc_pkg.sv @@
// Shared types and constants for the point-in-polygon crossing block.
`timescale 1ns / 1ps

package ppc_pkg;

    localparam int COORD_BITS    = 11;
    localparam int DIFF_BITS     = COORD_BITS + 1;
    localparam int PROD_BITS     = 2 * DIFF_BITS;
    localparam int IN_DATA_BITS  = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = 8;
    localparam int QDEPTH        = 4;
    localparam int QPTR_BITS     = $clog2(QDEPTH);
    localparam int QCNT_BITS     = $clog2(QDEPTH + 1);

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic   valid;
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
    } edge_t;

    typedef struct packed {
        coord_t qx;
        coord_t qy;
        edge_t  e0;
        edge_t  e1;
        logic   first;
        logic   last;
    } job_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic [QCNT_BITS-1:0] count;
    } qstat_t;

endpackage

@@ rtl/point_in_polygon_crossing.sv @@
// Top level of the even-odd ray-crossing point-in-polygon block.
//
//  channel  dir  payload
//  s_axis   in   tdata: query_x, query_y, vertex_x, vertex_y; tlast: last_vertex
//  m_axis   out  tdata: inside_res
//
// One vertex transaction per cycle while the queue has room; the result of a polygon
// passes through the queue, the product stage and the parity stage after its last vertex.
// Reset clears the polygon state, the queue and the result valid flag.
// A stalled output holds the back end; the front keeps taking vertices until
// the four-entry queue fills.
`timescale 1ns / 1ps

module point_in_polygon_crossing (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // query_x, query_y, vertex_x, vertex_y, zero pad
    input  logic [ppc_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // inside_res, zero pad
    output logic [ppc_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);
    import ppc_pkg::*;

    logic    push_valid, push_ready, pop_valid, pop;
    job_t    push_job, pop_job;
    qstat_t  qstat;

    ppc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_job      (push_job)
    );

    ppc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_job    (pop_job),
        .stat       (qstat)
    );

    ppc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (pop_valid),
        .job           (pop_job),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    a_qcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.count <= QCNT_BITS'(QDEPTH))
        else $error("queue count above depth");

    a_qcount_push: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.push && !qstat.pop |=> qstat.count == $past(qstat.count) + 1'b1)
        else $error("queue count did not advance on push");

    a_qcount_pop: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.pop && !qstat.push |=> qstat.count == $past(qstat.count) - 1'b1)
        else $error("queue count did not drop on pop");

    a_accept_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |-> qstat.push)
        else $error("accepted vertex not queued");

endmodule

@@ rtl/ppc_front.sv @@
// Front end: accepts vertex transactions, tracks polygon state, builds edge jobs.
`timescale 1ns / 1ps

module ppc_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [ppc_pkg::IN_DATA_BITS-1:0] s_axis_tdata,
    input  logic                             s_axis_tlast,
    output logic                             push_valid,
    input  logic                             push_ready,
    output ppc_pkg::job_t                    push_job
);
    import ppc_pkg::*;

    coord_t first_vx_reg, first_vy_reg, first_vx_next, first_vy_next;
    coord_t prev_vx_reg, prev_vy_reg;
    coord_t held_qx_reg, held_qy_reg, held_qx_next, held_qy_next;
    logic   mid_reg, mid_next;
    coord_t in_qx, in_qy, in_vx, in_vy;
    logic   accept;

    assign in_qx = s_axis_tdata[COORD_BITS-1:0];
    assign in_qy = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_vx = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign in_vy = s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];

    assign s_axis_tready = push_ready;
    assign push_valid    = s_axis_tvalid;
    assign accept        = s_axis_tvalid && push_ready;

    always_comb
    begin
        held_qx_next  = mid_reg ? held_qx_reg  : in_qx;
        held_qy_next  = mid_reg ? held_qy_reg  : in_qy;
        first_vx_next = mid_reg ? first_vx_reg : in_vx;
        first_vy_next = mid_reg ? first_vy_reg : in_vy;
        mid_next      = !s_axis_tlast;

        push_job.qx       = held_qx_next;
        push_job.qy       = held_qy_next;
        push_job.e0.valid = mid_reg;
        push_job.e0.ax    = in_vx;
        push_job.e0.ay    = in_vy;
        push_job.e0.bx    = prev_vx_reg;
        push_job.e0.by    = prev_vy_reg;
        push_job.e1.valid = s_axis_tlast;
        push_job.e1.ax    = first_vx_next;
        push_job.e1.ay    = first_vy_next;
        push_job.e1.bx    = in_vx;
        push_job.e1.by    = in_vy;
        push_job.first    = !mid_reg;
        push_job.last     = s_axis_tlast;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg      <= 1'b0;
            first_vx_reg <= '0;
            first_vy_reg <= '0;
            prev_vx_reg  <= '0;
            prev_vy_reg  <= '0;
            held_qx_reg  <= '0;
            held_qy_reg  <= '0;
        end
        else if (accept)
        begin
            mid_reg      <= mid_next;
            first_vx_reg <= first_vx_next;
            first_vy_reg <= first_vy_next;
            prev_vx_reg  <= in_vx;
            prev_vy_reg  <= in_vy;
            held_qx_reg  <= held_qx_next;
            held_qy_reg  <= held_qy_next;
        end
    end

endmodule

@@ rtl/ppc_queue.sv @@
// Job queue between the front end and the crossing back end.
`timescale 1ns / 1ps

module ppc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  ppc_pkg::job_t        push_job,
    output logic                 pop_valid,
    input  logic                 pop,
    output ppc_pkg::job_t        pop_job,
    output ppc_pkg::qstat_t      stat
);
    import ppc_pkg::*;

    job_t                 mem_reg [QDEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg, count_next;
    logic                 do_push, do_pop;

    assign push_ready = count_reg != QCNT_BITS'(QDEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_job    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    assign stat.push  = do_push;
    assign stat.pop   = do_pop;
    assign stat.count = count_reg;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/ppc_back.sv @@
// Back end: edge crossing products, parity update and result register.
`timescale 1ns / 1ps

module ppc_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              job_valid,
    input  ppc_pkg::job_t                     job,
    output logic                              pop,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ppc_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);
    import ppc_pkg::*;

    typedef struct packed {
        logic signed [PROD_BITS-1:0] lhs;
        logic signed [PROD_BITS-1:0] rhs;
        logic                        hit;
        logic                        asc;
    } terms_t;

    function automatic terms_t edge_terms(coord_t qx, coord_t qy, edge_t e);
        logic signed [DIFF_BITS-1:0] dx, dy, dqx, dqy;
        terms_t t;
        dx    = $signed({1'b0, e.bx}) - $signed({1'b0, e.ax});
        dy    = $signed({1'b0, e.by}) - $signed({1'b0, e.ay});
        dqx   = $signed({1'b0, qx})   - $signed({1'b0, e.ax});
        dqy   = $signed({1'b0, qy})   - $signed({1'b0, e.ay});
        t.lhs = dqy * dx;
        t.rhs = dqx * dy;
        t.hit = e.valid && ((e.ay < qy && e.by >= qy) || (e.by < qy && e.ay >= qy));
        t.asc = e.ay < e.by;
        return t;
    endfunction

    function automatic logic crosses(terms_t t);
        logic lt, gt;
        lt = $signed(t.lhs) < $signed(t.rhs);
        gt = $signed(t.lhs) > $signed(t.rhs);
        return t.hit && (t.asc ? lt : gt);
    endfunction

    terms_t t0_reg, t1_reg;
    logic   a_valid_reg, a_first_reg, a_last_reg;
    logic   parity_reg, parity_next;
    logic   out_valid_reg, inside_reg;
    logic   adv;

    assign adv           = !out_valid_reg || m_axis_tready;
    assign pop           = adv && job_valid;
    assign parity_next   = (a_first_reg ? 1'b0 : parity_reg) ^ crosses(t0_reg) ^ crosses(t1_reg);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_BITS-1){1'b0}}, inside_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t0_reg      <= edge_terms(job.qx, job.qy, job.e0);
            t1_reg      <= edge_terms(job.qx, job.qy, job.e1);
            a_first_reg <= job.first;
            a_last_reg  <= job.last;
            inside_reg  <= parity_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            parity_reg    <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= job_valid;
            out_valid_reg <= a_valid_reg && a_last_reg;
            if (a_valid_reg)
            begin
                parity_reg <= parity_next;
            end
        end
    end

endmodule

@@ test/testbench.sv @@
// Testbench for the point-in-polygon crossing block with a parity predictor.
`timescale 1ns / 1ps

module testbench;

    import ppc_pkg::*;

    localparam int PAD_BITS    = IN_DATA_BITS - 4 * COORD_BITS;
    localparam int LONG_HOLD   = 300;
    localparam int HOLD_AT     = 30;
    localparam int PHASE_ITEMS = 140;

    typedef struct {
        coord_t qx;
        coord_t qy;
        coord_t vx;
        coord_t vy;
        logic   is_last;
    } vertex_item_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_DATA_BITS-1:0]  s_axis_tdata = '0;
    logic                     s_axis_tlast = 1'b0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;

    vertex_item_t pending_vertices[$];
    bit           inside_expected[$];

    int send_idle_pct = 24;
    int recv_idle_pct = 69;
    int errors = 0;
    int results_seen = 0;
    int hold_left = 0;
    bit hold_taken = 1'b0;

    bit     poly_open = 1'b0;
    bit     crossing_parity = 1'b0;
    coord_t probe_x = '0;
    coord_t probe_y = '0;
    coord_t anchor_x = '0;
    coord_t anchor_y = '0;
    coord_t trail_x = '0;
    coord_t trail_y = '0;

    point_in_polygon_crossing i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic bit ray_crosses(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                                       coord_t px, coord_t py);
        longint x0;
        longint y0;
        longint x1;
        longint y1;
        longint rx;
        longint ry;
        longint dy;
        longint lhs;
        longint rhs;
        x0 = ax;
        y0 = ay;
        x1 = bx;
        y1 = by;
        rx = px;
        ry = py;
        if (!((y0 < ry && y1 >= ry) || (y1 < ry && y0 >= ry)))
            return 1'b0;
        dy  = y1 - y0;
        lhs = (ry - y0) * (x1 - x0);
        rhs = (rx - x0) * dy;
        return (dy > 0) ? (lhs < rhs) : (lhs > rhs);
    endfunction

    task automatic track_vertex(logic [IN_DATA_BITS-1:0] data, logic is_last);
        coord_t vx;
        coord_t vy;
        vx = data[2*COORD_BITS +: COORD_BITS];
        vy = data[3*COORD_BITS +: COORD_BITS];
        if (!poly_open)
        begin
            probe_x         = data[0 +: COORD_BITS];
            probe_y         = data[COORD_BITS +: COORD_BITS];
            anchor_x        = vx;
            anchor_y        = vy;
            crossing_parity = 1'b0;
            poly_open       = 1'b1;
        end
        else
        begin
            crossing_parity ^= ray_crosses(vx, vy, trail_x, trail_y, probe_x, probe_y);
        end
        trail_x = vx;
        trail_y = vy;
        if (is_last)
        begin
            crossing_parity ^= ray_crosses(anchor_x, anchor_y, vx, vy, probe_x, probe_y);
            inside_expected = {inside_expected, crossing_parity};
            poly_open = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
        end
        else
        begin
            vertex_item_t item;
            if (s_axis_tvalid && s_axis_tready)
                track_vertex(s_axis_tdata, s_axis_tlast);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_vertices.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    item = pending_vertices.pop_front();
                    s_axis_tdata  <= {{PAD_BITS{1'b0}}, item.vy, item.vx, item.qy, item.qx};
                    s_axis_tlast  <= item.is_last;
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            bit want;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (inside_expected.size() == 0)
                begin
                    $display("%0t: unexpected inside_res %0d, expected none", $time,
                             m_axis_tdata[0]);
                    errors++;
                end
                else
                begin
                    want = inside_expected.pop_front();
                    if (m_axis_tdata[0] !== want)
                    begin
                        $display("%0t: inside_res expected %0d, actual %0d", $time, want,
                                 m_axis_tdata[0]);
                        errors++;
                    end
                end
                results_seen <= results_seen + 1;
            end
            // hold off the output for a long stretch once, mid-run
            if (hold_left != 0)
            begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (results_seen == HOLD_AT && !hold_taken)
            begin
                hold_taken    <= 1'b1;
                hold_left     <= LONG_HOLD;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic add_vertex(coord_t qx, coord_t qy, coord_t vx, coord_t vy, logic is_last);
        vertex_item_t item;
        item.qx      = qx;
        item.qy      = qy;
        item.vx      = vx;
        item.vy      = vy;
        item.is_last = is_last;
        pending_vertices = {pending_vertices, item};
    endtask

    task automatic add_random_polygon(output int count);
        int span;
        int ox;
        int oy;
        int n;
        case ($urandom_range(3))
            0: span = 3;
            1: span = 31;
            2: span = 255;
            default: span = 2047;
        endcase
        ox = $urandom_range(2047 - span);
        oy = $urandom_range(2047 - span);
        n  = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
        for (int k = 0; k < n; k++)
        begin
            if (k == 0)
                add_vertex(coord_t'(ox + $urandom_range(span)),
                           coord_t'(oy + $urandom_range(span)),
                           coord_t'(ox + $urandom_range(span)),
                           coord_t'(oy + $urandom_range(span)), n == 1);
            else
                add_vertex(coord_t'($urandom_range(2047)), coord_t'($urandom_range(2047)),
                           coord_t'(ox + $urandom_range(span)),
                           coord_t'(oy + $urandom_range(span)), k == n - 1);
        end
        count = n;
    endtask

    task automatic drain();
        while (pending_vertices.size() != 0 || s_axis_tvalid || inside_expected.size() != 0)
            @(negedge clk);
    endtask

    task automatic random_phase(int send_pct, int recv_pct);
        int added;
        int n;
        @(negedge clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        added = 0;
        while (added < PHASE_ITEMS)
        begin
            add_random_polygon(n);
            added += n;
        end
        drain();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        add_vertex(2047, 2047, 2047, 2047, 1'b1);
        add_vertex(0, 0, 0, 0, 1'b1);
        add_vertex(1024, 1024, 0, 0, 1'b0);
        add_vertex(0, 0, 2047, 2047, 1'b1);
        add_vertex(1024, 1024, 0, 0, 1'b0);
        add_vertex(2047, 2047, 2047, 0, 1'b0);
        add_vertex(2047, 2047, 2047, 2047, 1'b0);
        add_vertex(0, 0, 0, 2047, 1'b1);
        add_vertex(0, 1024, 0, 0, 1'b0);
        add_vertex(2047, 0, 2047, 0, 1'b0);
        add_vertex(0, 2047, 2047, 2047, 1'b0);
        add_vertex(1365, 682, 0, 2047, 1'b1);
        add_vertex(4, 3, 5, 10, 1'b0);
        add_vertex(2047, 2047, 10, 0, 1'b0);
        add_vertex(0, 0, 0, 0, 1'b1);
        add_vertex(2047, 0, 10, 0, 1'b0);
        add_vertex(0, 2047, 20, 2047, 1'b0);
        add_vertex(2047, 0, 0, 2047, 1'b1);
        drain();
        random_phase(24, 69);
        random_phase(69, 24);
        random_phase(0, 0);
        repeat (20) @(posedge clk);
        if (inside_expected.size() != 0)
            errors++;
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
